[hw/rtl/rcl_pkg.sv]
// shared types, constants and color functions for the rainbow chase level bar
package rcl_pkg;

    // one rgb pixel as held in the pixel store
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // frame sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN
    } t_state;

    // configuration register indexes
    localparam logic CFG_RUN_LEN   = 1'b0;
    localparam logic CFG_FADE_STEP = 1'b1;

    // reset values of the configuration registers
    localparam logic [5:0] RUN_LEN_RST   = 6'd7;
    localparam logic [7:0] FADE_STEP_RST = 8'd36;

    // palette: grey, red, orange, yellow, green, light blue, blue, violet
    function automatic t_rgb hue(input logic [2:0] pos);
        t_rgb c;
        unique case (pos)
            3'd0: c = '{red: 8'd150, green: 8'd150, blue: 8'd150};
            3'd1: c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            3'd2: c = '{red: 8'd255, green: 8'd100, blue: 8'd0};
            3'd3: c = '{red: 8'd100, green: 8'd255, blue: 8'd0};
            3'd4: c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            3'd5: c = '{red: 8'd0,   green: 8'd100, blue: 8'd255};
            3'd6: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            3'd7: c = '{red: 8'd100, green: 8'd0,   blue: 8'd255};
            default: c = '0;
        endcase
        return c;
    endfunction

    // move one channel by step toward target, holding inside the step window
    function automatic logic [7:0] fade_chan(input logic [7:0] cur,
                                             input logic [7:0] tgt,
                                             input logic [7:0] step);
        logic signed [10:0] c;
        logic signed [10:0] t;
        logic signed [10:0] f;
        c = signed'({3'b000, cur});
        t = signed'({3'b000, tgt});
        f = signed'({3'b000, step});
        if (c < t - f) begin
            c = c + f;
        end
        if (c > t + f) begin
            c = c - f;
        end
        return c[7:0];
    endfunction

endpackage

[hw/rtl/rainbow_chase_level_bar.sv]
// top level: rainbow chase led level bar frame generator
//
//   channel   signals                                   direction
//   level     i_valid, o_stall, i_level                 in
//   pixel     o_valid, i_stall, o_pixel_index, o_red,   out
//             o_green, o_blue, o_last_pixel
//   config    i_cfg_we, i_cfg_idx, i_cfg_data           in
//
// one level transaction yields NUM_PIXELS pixel transactions, one per cycle while
// i_stall is low; the sweep runs through the single read / single write pixel
// store (one read and one write a cycle)
// after reset a clearing pass zeroes the store, o_stall high
// i_stall holds the sweep; the last pixel may wait while the next level is taken
module rainbow_chase_level_bar #(
    parameter int NUM_PIXELS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // level channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_level,
    // pixel channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_pixel_index,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_last_pixel,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import rcl_pkg::*;

    localparam int AW = $clog2(NUM_PIXELS);
    localparam int CW = $clog2(NUM_PIXELS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PIXELS - 1);
    localparam logic [CW-1:0] NUM_CNT   = CW'(NUM_PIXELS);

    t_state r_state;
    t_state n_state;

    logic [5:0]    r_run_len;
    logic [7:0]    r_fade_step;
    logic [2:0]    r_pal;
    logic [6:0]    r_run;
    logic [3:0]    r_level;
    logic [AW-1:0] r_clr_addr;
    logic [CW-1:0] r_rd_addr;
    logic [AW-1:0] r_cur;
    logic          r_data_vld;
    t_rgb          r_prev;

    logic          r_out_vld;
    logic [3:0]    r_out_idx;
    t_rgb          r_out_px;
    logic          r_out_last;

    logic          in_acc;
    logic          adv;
    logic          rd_en;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_rgb          ram_wdata;
    t_rgb          ram_rdata;
    t_rgb          head_px;
    t_rgb          new_px;
    logic          blank;
    logic          cur_last;

    // pixel store
    rcl_pixel_ram #(
        .NUM_PIXELS(NUM_PIXELS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (rd_en),
        .i_raddr(r_rd_addr[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    // head pixel fade toward palette color
    rcl_head_fade u_fade (
        .i_pixel      (ram_rdata),
        .i_palette_pos(r_pal),
        .i_fade_step  (r_fade_step),
        .o_pixel      (head_px)
    );

    // sweep handshake: a pixel moves on when read data is there and the output slot frees
    assign in_acc   = (r_state == S_IDLE) && i_valid;
    assign cur_last = (r_cur == LAST_ADDR);
    assign adv      = (r_state == S_RUN) && r_data_vld && (!r_out_vld || !i_stall);
    assign rd_en    = (r_state == S_RUN) && (r_rd_addr < NUM_CNT) && (!r_data_vld || adv);

    // new pixel: zero at index >= level, head fades, rest take inner neighbor's old value
    assign blank  = (7'(r_cur) >= 7'(r_level));
    assign new_px = blank ? '0 : ((r_cur == '0) ? head_px : r_prev);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = S_RUN;
            S_RUN:   if (adv && cur_last) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // state outputs: store write port and input stall
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = new_px;
        o_stall   = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_RUN: begin
                ram_we = adv;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // state register and clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len   <= RUN_LEN_RST;
            r_fade_step <= FADE_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RUN_LEN:   r_run_len   <= i_cfg_data[5:0];
                CFG_FADE_STEP: r_fade_step <= i_cfg_data;
                default:       r_fade_step <= r_fade_step;
            endcase
        end
    end

    // palette advance: step the color once the frame run count passes the run length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal <= 3'd1;
            r_run <= 7'd1;
        end else if (in_acc) begin
            if (r_run > {1'b0, r_run_len}) begin
                r_pal <= r_pal + 3'd1;
                r_run <= 7'd1;
            end else begin
                r_run <= r_run + 7'd1;
            end
        end
    end

    // sweep counters and read data tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr  <= '0;
            r_cur      <= '0;
            r_data_vld <= 1'b0;
        end else if (in_acc) begin
            r_rd_addr  <= '0;
            r_cur      <= '0;
            r_data_vld <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
            if (adv) begin
                r_cur <= r_cur + 1'b1;
            end
            if (rd_en) begin
                r_data_vld <= 1'b1;
            end else if (adv) begin
                r_data_vld <= 1'b0;
            end
        end
    end

    // frame payload: level and the previous old pixel
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_level <= i_level;
        end
        if (adv) begin
            r_prev <= ram_rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_idx  <= 4'(r_cur);
            r_out_px   <= new_px;
            r_out_last <= cur_last;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_pixel_index = r_out_idx;
    assign o_red         = r_out_px.red;
    assign o_green       = r_out_px.green;
    assign o_blue        = r_out_px.blue;
    assign o_last_pixel  = r_out_last;

    // checks
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_pixel |-> o_pixel_index == 4'(NUM_PIXELS - 1))
        else $error("last pixel flag on wrong index");

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("level taken without starting a frame");

    a_no_output_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_valid && !rd_en)
        else $error("activity during clearing pass");

    a_write_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && ram_we |-> r_data_vld)
        else $error("store written without read data");

endmodule

[hw/rtl/rcl_pixel_ram.sv]
// pixel store: single write port, single read port with registered read data
module rcl_pixel_ram #(
    parameter int NUM_PIXELS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(NUM_PIXELS)-1:0] i_waddr,
    input  rcl_pkg::t_rgb                 i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(NUM_PIXELS)-1:0] i_raddr,
    output rcl_pkg::t_rgb                 o_rdata
);
    import rcl_pkg::*;

    t_rgb r_mem [NUM_PIXELS];
    t_rgb r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rcl_head_fade.sv]
// head pixel update: fade each channel toward the current palette color
module rcl_head_fade (
    input  rcl_pkg::t_rgb i_pixel,
    input  logic [2:0]    i_palette_pos,
    input  logic [7:0]    i_fade_step,
    output rcl_pkg::t_rgb o_pixel
);
    import rcl_pkg::*;

    t_rgb target;

    // palette lookup
    assign target = hue(i_palette_pos);

    // per channel fade
    assign o_pixel.red   = fade_chan(i_pixel.red,   target.red,   i_fade_step);
    assign o_pixel.green = fade_chan(i_pixel.green, target.green, i_fade_step);
    assign o_pixel.blue  = fade_chan(i_pixel.blue,  target.blue,  i_fade_step);

endmodule

[test/rainbow_chase_level_bar_checker.sv]
// pixel frame predictor and scoreboard for the rainbow chase level bar
`timescale 1ns / 100ps

module rainbow_chase_level_bar_checker #(
    parameter int NUM_PIXELS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // level channel
    input  logic       i_lvl_valid,
    input  logic       i_lvl_stall,
    input  logic [3:0] i_level,
    // pixel channel
    input  logic       i_pix_valid,
    input  logic       i_pix_stall,
    input  logic [3:0] i_pixel_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_last_pixel,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // status for the test top
    output int         o_errors,
    output int         o_pending,
    output int         o_frames,
    output int         o_pixels
);
    import rcl_pkg::*;

    typedef struct packed {
        logic [3:0] index;
        t_rgb       rgb;
        logic       last;
    } t_pixel_out;

    // palette colors as red, green, blue bytes
    localparam logic [23:0] PALETTE [8] = '{
        24'h969696, 24'hFF0000, 24'hFF6400, 24'h64FF00,
        24'h00FF00, 24'h0064FF, 24'h0000FF, 24'h6400FF
    };

    // shadow of the bar state and the registers
    t_rgb       chain [NUM_PIXELS];
    logic [2:0] hue_pos;
    logic [6:0] run_count;
    logic [5:0] run_len;
    logic [7:0] fade_amt;

    t_pixel_out frame_q [$];
    int err_count;
    int frame_count;
    int pixel_count;

    // one channel moves by the step unless already within a step of the target
    function automatic logic [7:0] fade_toward_target(input logic [7:0] cur,
                                                      input logic [7:0] tgt,
                                                      input logic [7:0] stp);
        int c;
        int t;
        int f;
        c = cur;
        t = tgt;
        f = stp;
        if (c < t - f) begin
            c = c + f;
        end
        if (c > t + f) begin
            c = c - f;
        end
        return c[7:0];
    endfunction

    // shift the chain, fade the head, blank above the level, queue the frame
    task automatic render_frame(input logic [3:0] lvl);
        t_rgb       tgt;
        t_pixel_out px;
        for (int p = NUM_PIXELS - 1; p > 0; p--) begin
            chain[p] = chain[p - 1];
        end
        if (run_count > {1'b0, run_len}) begin
            hue_pos   = hue_pos + 3'd1;
            run_count = '0;
        end
        run_count = run_count + 7'd1;
        tgt = PALETTE[hue_pos];
        chain[0].red   = fade_toward_target(chain[0].red, tgt.red, fade_amt);
        chain[0].green = fade_toward_target(chain[0].green, tgt.green, fade_amt);
        chain[0].blue  = fade_toward_target(chain[0].blue, tgt.blue, fade_amt);
        for (int p = 0; p < NUM_PIXELS; p++) begin
            if (p >= lvl) begin
                chain[p] = '0;
            end
        end
        for (int p = 0; p < NUM_PIXELS; p++) begin
            px.index = 4'(p);
            px.rgb   = chain[p];
            px.last  = (p == NUM_PIXELS - 1);
            frame_q.push_back(px);
        end
        frame_count++;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            err_count++;
            $display("%0t: pixel %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // match one pixel transaction against the oldest expected pixel
    task automatic check_pixel();
        t_pixel_out want;
        pixel_count++;
        if (frame_q.size() == 0) begin
            err_count++;
            $display("%0t: unexpected pixel, expected none, actual index %0d rgb %h last %b",
                     $time, i_pixel_index, {i_red, i_green, i_blue}, i_last_pixel);
        end else begin
            want = frame_q.pop_front();
            compare_field("index", want.index, i_pixel_index);
            compare_field("red", want.rgb.red, i_red);
            compare_field("green", want.rgb.green, i_green);
            compare_field("blue", want.rgb.blue, i_blue);
            compare_field("last", want.last, i_last_pixel);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (chain[p]) begin
                chain[p] = '0;
            end
            hue_pos   = 3'd1;
            run_count = 7'd1;
            run_len   = RUN_LEN_RST;
            fade_amt  = FADE_STEP_RST;
            frame_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RUN_LEN:   run_len  = i_cfg_data[5:0];
                    CFG_FADE_STEP: fade_amt = i_cfg_data;
                    default: ;
                endcase
            end
            // level transaction queues a frame, pixel transaction is checked
            if (i_lvl_valid && !i_lvl_stall) begin
                render_frame(i_level);
            end
            if (i_pix_valid && !i_pix_stall) begin
                check_pixel();
            end
        end
        o_errors  <= err_count;
        o_pending <= frame_q.size();
        o_frames  <= frame_count;
        o_pixels  <= pixel_count;
    end

endmodule

[test/rainbow_chase_level_bar_test.sv]
// stimulus, clock, reset and verdict for the rainbow chase level bar
`timescale 1ns / 100ps

module rainbow_chase_level_bar_test;
    import rcl_pkg::*;

    localparam int NUM_PIXELS  = 14;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS    = 10;
    localparam int SEG_LEVELS  = 44;
    localparam int HOLD_CYCLES = 300;

    // sender idle and receiver stall percentages, one pair per mix
    localparam int SEND_IDLE  [5] = '{0, 84, 0, 31, 0};
    localparam int RECV_STALL [5] = '{0, 0, 84, 31, 0};

    // opening levels: full bar, top edge, blank bar, partial bars
    localparam logic [3:0] OPENING_LEVELS [12] = '{
        4'd15, 4'd14, 4'd15, 4'd15, 4'd13, 4'd1,
        4'd0,  4'd15, 4'd7,  4'd8,  4'd15, 4'd12
    };

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic [3:0] i_level    = 4'd0;
    logic       i_stall    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_idx  = CFG_RUN_LEN;
    logic [7:0] i_cfg_data = 8'd0;
    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_pixel_index;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic       o_last_pixel;

    int errors;
    int pending;
    int frames;
    int pixels;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int settings_count = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    rainbow_chase_level_bar #(
        .NUM_PIXELS(NUM_PIXELS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_level      (i_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_index(o_pixel_index),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_last_pixel (o_last_pixel),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    rainbow_chase_level_bar_checker #(
        .NUM_PIXELS(NUM_PIXELS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lvl_valid  (i_valid),
        .i_lvl_stall  (o_stall),
        .i_level      (i_level),
        .i_pix_valid  (o_valid),
        .i_pix_stall  (i_stall),
        .i_pixel_index(o_pixel_index),
        .i_red        (o_red),
        .i_green      (o_green),
        .i_blue       (o_blue),
        .i_last_pixel (o_last_pixel),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_frames     (frames),
        .o_pixels     (pixels)
    );

    // offer one level transaction, then maybe go idle for a while
    task automatic send_level(input logic [3:0] lvl);
        i_valid <= 1'b1;
        i_level <= lvl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_level <= 4'($urandom);
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every expected pixel
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // write both registers on back-to-back cycles
    task automatic apply_settings(input logic [5:0] run, input logic [7:0] fade);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RUN_LEN;
        i_cfg_data <= {2'b00, run};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FADE_STEP;
        i_cfg_data <= fade;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_count++;
    endtask

    // pixel receiver: random stall, or a long hold-off on request
    initial begin : receiver
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit hit with %0d pixels outstanding", pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int         mix;
        int         r;
        logic [5:0] run;
        logic [7:0] fade;
        logic [3:0] lvl;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, level extremes, blank and full bars
        foreach (OPENING_LEVELS[k]) begin
            send_level(OPENING_LEVELS[k]);
        end
        // zero run length advances the color each frame; full step fade holds
        drain();
        apply_settings(6'd0, 8'd255);
        repeat (4) send_level(4'd15);
        // longest run with zero fade keeps the head fixed
        drain();
        apply_settings(6'd63, 8'd0);
        repeat (3) send_level(4'd15);
        // run length lowered mid run, largest nominal fade
        drain();
        apply_settings(6'd1, 8'd128);
        repeat (3) send_level(4'd14);

        // random segments, two per idle and stall mix, new settings each
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            mix = seg / 2;
            drain();
            if (seg == 0) begin
                run  = 6'd32;
                fade = 8'd1;
            end else begin
                case ($urandom_range(0, 5))
                    0:       run = 6'd0;
                    1:       run = 6'd1;
                    2:       run = 6'd32;
                    3:       run = 6'd63;
                    default: run = 6'($urandom_range(1, 32));
                endcase
                case ($urandom_range(0, 5))
                    0:       fade = 8'd0;
                    1:       fade = 8'd1;
                    2:       fade = 8'd128;
                    3:       fade = 8'd255;
                    default: fade = 8'($urandom_range(1, 128));
                endcase
            end
            apply_settings(run, fade);
            send_idle_pct  = SEND_IDLE[mix];
            recv_stall_pct = RECV_STALL[mix];
            // last mix: receiver holds off while levels keep coming
            if (mix == 4) begin
                hold_len = HOLD_CYCLES;
            end
            for (int k = 0; k < SEG_LEVELS; k++) begin
                // mostly lit bars so colors travel down the chain
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    lvl = 4'($urandom_range(13, 15));
                end else begin
                    lvl = 4'($urandom_range(0, 15));
                end
                send_level(lvl);
            end
        end

        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2 * NUM_PIXELS + 8) @(posedge i_clk);

        $display("covered %0d level frames, %0d pixels, %0d register settings",
                 frames, pixels, settings_count);
        $display("five idle and stall mixes including a %0d cycle receiver hold-off",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
